/* hdl/mono_bitmap_blitter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome bitmap blitter
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MONO_BITMAP_BLITTER_ASSERT_SVH
`define MONO_BITMAP_BLITTER_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define MBB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The expression must never be true outside reset.
`define MBB_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

/* hdl/mbb_pkg.sv */
// ----------------------------------------------------------------------------
// Monochrome bitmap blitter package
// Item kinds and byte constants used by the block.
// ----------------------------------------------------------------------------
package mbb_pkg;

   // Kind of a request item, as carried on the action field.
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_READ  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;
   localparam int         BYTE_BITS  = 8;

endpackage

/* hdl/mbb_if.sv */
// ----------------------------------------------------------------------------
// Monochrome bitmap blitter channels
// Valid/ready channel interfaces for request items and read responses.
// ----------------------------------------------------------------------------
interface mbb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  pos_x;
   logic [6:0]  pos_y;
   logic [7:0]  bitmap_width;
   logic [7:0]  bitmap_height;
   logic        invert;
   logic [7:0]  data_byte;
   logic [11:0] store_address;

   modport source (
      output valid, action, pos_x, pos_y, bitmap_width, bitmap_height, invert,
             data_byte, store_address,
      input  ready
   );
   modport sink (
      input  valid, action, pos_x, pos_y, bitmap_width, bitmap_height, invert,
             data_byte, store_address,
      output ready
   );
endinterface

interface mbb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

/* hdl/mono_bitmap_blitter.sv */
// ----------------------------------------------------------------------------
// Monochrome bitmap blitter
// Built-in 1 bpp framebuffer with a shifted read-modify-write blit engine.
// ----------------------------------------------------------------------------
// Usage: request items arrive on req_if. A start item latches the blit
// position, width, height and invert flag. Each data item then carries one
// bitmap byte, row-major; it is merged into one or two framebuffer bytes.
// Read items return one byte on rsp_if; write items store a raw byte.
// Data, read and write items pass the merge stage one at a time: the
// framebuffer has a single write port, and a data item at a nonzero bit
// offset needs two writes. Start items and data items outside an active
// blit do not enter the merge stage. A read result passes the merge stage
// and then sits in an output register.
// After reset the block sweeps the framebuffer to zero, one byte per cycle
// (LINE_BYTES*LINES bytes, 3840 by default), with req_if.ready held low.
// When the receiver stalls a read result, the next items are still accepted
// until another read reaches the merge stage; that read then waits there and
// req_if.ready drops until the output register drains.
// ----------------------------------------------------------------------------
`include "mono_bitmap_blitter_assert.svh"

module mono_bitmap_blitter #(
   parameter int LINE_BYTES = 30,
   parameter int LINES      = 128
) (
   input logic          clock,
   input logic          reset,
   mbb_req_if.sink      req_if,
   mbb_rsp_if.source    rsp_if
);

   localparam int StoreBytes = LINE_BYTES * LINES;
   localparam int MemAw      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
   // Destination addresses run past the store when a blit hangs off the
   // bottom; they are kept wide enough never to wrap.
   localparam int RowMax     = (128 + 256) * LINE_BYTES + 4096 + 64;
   localparam int RowW       = $clog2(RowMax);
   localparam logic [RowW-1:0]  StoreLimit = RowW'(StoreBytes);
   localparam logic [MemAw-1:0] LastAddr   = MemAw'(StoreBytes - 1);

   // Merge stage context, loaded at the transfer of a read, write or data item.
   typedef struct packed {
      mbb_pkg::op_type   op;
      logic [MemAw-1:0]  addr0;
      logic              ok0;
      logic [MemAw-1:0]  addr1;
      logic              ok1;
      logic [2:0]        off;
      logic [7:0]        bits;
   } merge_type;

   // Second write of a data item: the right neighbor byte.
   typedef struct packed {
      logic [MemAw-1:0] addr;
      logic [7:0]       data;
   } tail_type;

   logic [7:0] frame_mem [StoreBytes];

   // Blit state.
   logic [RowW-1:0] row_base_ff, row_base_in;
   logic [2:0]      bit_offset_ff, bit_offset_in;
   logic [4:0]      bytes_per_row_ff, bytes_per_row_in;
   logic [4:0]      column_count_ff, column_count_in;
   logic [7:0]      rows_left_ff, rows_left_in;
   logic [7:0]      invert_mask_ff, invert_mask_in;

   // Clearing sweep after reset.
   logic             clearing_ff;
   logic [MemAw-1:0] clr_addr_ff;

   // Pipeline.
   logic      s1_valid_ff, s1_valid_in;
   merge_type s1_ff, s1_in;
   logic      s2_valid_ff, s2_valid_in;
   tail_type  s2_ff, s2_in;
   logic      s1_advance;

   // Memory ports and forwarding.
   logic             wr_en;
   logic [MemAw-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [MemAw-1:0] ra0, ra1;
   logic [7:0]       rd0_ff, rd1_ff;
   logic             fwd0_ff, fwd1_ff;
   logic [7:0]       fwd_data_ff;
   logic [7:0]       rd0, rd1;

   // Output register.
   logic       rsp_valid_ff;
   logic [7:0] read_data_ff;

   logic            accept;
   mbb_pkg::op_type req_op;
   logic [RowW-1:0] dst0, dst1, req_addr;
   logic [5:0]      column_next;
   logic [7:0]      shaped;
   logic [7:0]      keep0, new0, new1;
   logic [3:0]      left_shift;

   assign accept = req_if.valid && req_if.ready;
   assign req_op = mbb_pkg::op_type'(req_if.action);

   // A single write port: one item sits in the merge stage at a time, so the
   // merge write, the tail write and the clearing sweep never coincide.
   assign req_if.ready = !s1_valid_ff && !clearing_ff;

   // Destination of the next bitmap byte and its right neighbor, which is
   // simply the next address even across a line end.
   assign dst0        = row_base_ff + RowW'(column_count_ff);
   assign dst1        = dst0 + RowW'(1);
   assign req_addr    = RowW'(req_if.store_address);
   assign column_next = {1'b0, column_count_ff} + 6'd1;
   assign shaped      = req_if.data_byte ^ invert_mask_ff;

   // Blit state update and merge stage loading at transfer time.
   always_comb begin
      row_base_in      = row_base_ff;
      bit_offset_in    = bit_offset_ff;
      bytes_per_row_in = bytes_per_row_ff;
      column_count_in  = column_count_ff;
      rows_left_in     = rows_left_ff;
      invert_mask_in   = invert_mask_ff;
      s1_in            = s1_ff;
      s1_valid_in      = s1_valid_ff && !s1_advance;
      ra0              = '0;
      ra1              = '0;

      if (accept) begin
         unique case (req_op)
            mbb_pkg::OP_START: begin
               row_base_in      = RowW'(req_if.pos_x >> 3)
                                + RowW'(req_if.pos_y) * RowW'(LINE_BYTES);
               bit_offset_in    = req_if.pos_x[2:0];
               bytes_per_row_in = req_if.bitmap_width[7:3];
               column_count_in  = '0;
               rows_left_in     = (req_if.bitmap_width[7:3] == 5'd0)
                                ? 8'd0 : req_if.bitmap_height;
               invert_mask_in   = req_if.invert ? mbb_pkg::BYTE_ONES
                                                : mbb_pkg::BYTE_ZEROS;
            end
            mbb_pkg::OP_DATA: begin
               // A byte outside an active blit is dropped here.
               if (rows_left_ff != 8'd0) begin
                  s1_valid_in = 1'b1;
                  s1_in.op    = mbb_pkg::OP_DATA;
                  s1_in.ok0   = dst0 < StoreLimit;
                  s1_in.ok1   = dst1 < StoreLimit;
                  s1_in.addr0 = s1_in.ok0 ? dst0[MemAw-1:0] : '0;
                  s1_in.addr1 = s1_in.ok1 ? dst1[MemAw-1:0] : '0;
                  s1_in.off   = bit_offset_ff;
                  s1_in.bits  = shaped;
                  ra0         = s1_in.addr0;
                  ra1         = s1_in.addr1;
                  if (column_next >= {1'b0, bytes_per_row_ff}) begin
                     column_count_in = '0;
                     row_base_in     = row_base_ff + RowW'(LINE_BYTES);
                     rows_left_in    = rows_left_ff - 8'd1;
                  end else begin
                     column_count_in = column_next[4:0];
                  end
               end
            end
            mbb_pkg::OP_READ, mbb_pkg::OP_WRITE: begin
               s1_valid_in = 1'b1;
               s1_in.op    = req_op;
               s1_in.ok0   = req_addr < StoreLimit;
               s1_in.addr0 = s1_in.ok0 ? req_addr[MemAw-1:0] : '0;
               s1_in.ok1   = 1'b0;
               s1_in.addr1 = '0;
               s1_in.off   = 3'd0;
               s1_in.bits  = req_if.data_byte;
               ra0         = s1_in.addr0;
            end
            default: begin
            end
         endcase
      end
   end

   // Merge stage. A read result waits here while the output register holds a result that rsp_if does not take.
   assign s1_advance = s1_valid_ff
                    && !(s1_ff.op == mbb_pkg::OP_READ && rsp_valid_ff && !rsp_if.ready);

   assign rd0        = fwd0_ff ? fwd_data_ff : rd0_ff;
   assign rd1        = fwd1_ff ? fwd_data_ff : rd1_ff;
   assign keep0      = ~(mbb_pkg::BYTE_ONES >> s1_ff.off);
   assign left_shift = 4'(mbb_pkg::BYTE_BITS) - {1'b0, s1_ff.off};
   assign new0       = (rd0 & keep0) | (s1_ff.bits >> s1_ff.off);
   assign new1       = (rd1 & ~keep0) | (s1_ff.bits << left_shift);

   always_comb begin
      s2_valid_in = 1'b0;
      s2_in.addr  = s1_ff.addr1;
      s2_in.data  = new1;
      if (s1_advance && s1_ff.op == mbb_pkg::OP_DATA && s1_ff.off != 3'd0
          && s1_ff.ok1) begin
         s2_valid_in = 1'b1;
      end
   end

   // Write port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s1_ff.addr0;
      wr_data = new0;
      priority if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = mbb_pkg::BYTE_ZEROS;
      end else if (s2_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = s2_ff.addr;
         wr_data = s2_ff.data;
      end else if (s1_valid_ff && s1_ff.ok0 && s1_ff.op == mbb_pkg::OP_DATA) begin
         wr_en   = 1'b1;
         wr_data = new0;
      end else if (s1_valid_ff && s1_ff.ok0 && s1_ff.op == mbb_pkg::OP_WRITE) begin
         wr_en   = 1'b1;
         wr_data = s1_ff.bits;
      end
   end

   // Framebuffer: one write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd0_ff <= frame_mem[ra0];
         rd1_ff <= frame_mem[ra1];
      end
   end

   // A read issued in the same cycle as a tail write to that byte would see
   // the old value, so the written byte is captured alongside.
   always_ff @(posedge clock) begin
      if (accept) begin
         fwd0_ff     <= wr_en && (wr_addr == ra0);
         fwd1_ff     <= wr_en && (wr_addr == ra1);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_base_ff      <= '0;
         bit_offset_ff    <= '0;
         bytes_per_row_ff <= '0;
         column_count_ff  <= '0;
         rows_left_ff     <= '0;
         invert_mask_ff   <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         clearing_ff      <= 1'b1;
         clr_addr_ff      <= '0;
      end else begin
         row_base_ff      <= row_base_in;
         bit_offset_ff    <= bit_offset_in;
         bytes_per_row_ff <= bytes_per_row_in;
         column_count_ff  <= column_count_in;
         rows_left_ff     <= rows_left_in;
         invert_mask_ff   <= invert_mask_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         if (s1_advance && s1_ff.op == mbb_pkg::OP_READ) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clearing_ff) begin
            if (clr_addr_ff == LastAddr) begin
               clearing_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + MemAw'(1);
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      if (s1_advance && s1_ff.op == mbb_pkg::OP_READ) begin
         read_data_ff <= s1_ff.ok0 ? rd0 : mbb_pkg::BYTE_ZEROS;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = read_data_ff;

   // The merge and tail writes share one port and must never overlap.
   `MBB_ASSERT_NEVER(a_stages_exclusive, s1_valid_ff && s2_valid_ff, "merge and tail stages overlap")
   // A tail write only ever follows a data item in the merge stage.
   `MBB_ASSERT(a_tail_from_data, s2_valid_ff |-> $past(s1_valid_ff && s1_ff.op == mbb_pkg::OP_DATA), "tail write without data item")
   // A new read result comes only from a read leaving the merge stage.
   `MBB_ASSERT(a_rsp_from_read, $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_ff.op == mbb_pkg::OP_READ), "response without read")
   // No item may reach the memory while the clearing sweep still runs.
   `MBB_ASSERT_NEVER(a_no_item_in_clear, clearing_ff && (s1_valid_ff || s2_valid_ff), "item during clearing sweep")

endmodule
